### hw/rtl/s2i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, constants and helpers of the streaming string to integer
// parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_CHARS  = 4096;
  localparam int POS_BITS   = $clog2(MAX_CHARS + 1);
  localparam int BASE_BITS  = 6;
  localparam int CHAR_BITS  = 8;
  localparam int PROD_BITS  = VALUE_BITS + BASE_BITS;

  localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
  localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = '1;

  localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] ALPHA_OFFSET = 8'd10;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_SOME,
    ST_OVER
  } status_t;

  typedef struct packed {
    phase_t                phase;
    logic                  negative;
    logic [BASE_BITS-1:0]  base;
    logic [VALUE_BITS-1:0] acc;
    status_t               status;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   dend;
  } state_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]          end_offset;
    logic                         range_error;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:    PH_SPACE,
    negative: 1'b0,
    base:     '0,
    acc:      '0,
    status:   ST_NONE,
    pos:      '0,
    dend:     '0
  };

  function automatic logic [BASE_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
    logic [BASE_BITS-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) d = BASE_BITS'(c - CH_0);
    else if (c >= CH_UA && c <= CH_UZ) d = BASE_BITS'(c - CH_UA + ALPHA_OFFSET);
    else if (c >= CH_LA && c <= CH_LZ) d = BASE_BITS'(c - CH_LA + ALPHA_OFFSET);
    return d;
  endfunction

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [POS_BITS-1:0] next_pos(input logic [POS_BITS-1:0] p);
    return (p >= POS_BITS'(MAX_CHARS)) ? POS_BITS'(MAX_CHARS) : p + POS_BITS'(1);
  endfunction

  function automatic logic [VALUE_BITS-1:0] mag_limit(input logic negative);
    logic [VALUE_BITS-1:0] top;
    top = VALUE_BITS'(1) << (VALUE_BITS - 1);
    return negative ? top : top - VALUE_BITS'(1);
  endfunction

endpackage

### hw/rtl/s2i_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_in_if
// Character request channel: one byte of the string and its end marker.
// ----------------------------------------------------------------------------
interface s2i_in_if;
  import s2i_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

### hw/rtl/s2i_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_out_if
// Result request channel: parsed value, end offset and range flag.
// ----------------------------------------------------------------------------
interface s2i_out_if;
  import s2i_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [POS_BITS-1:0]          end_offset;
  logic                         range_error;

  modport source (output valid, output value, output end_offset, output range_error,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input range_error,
                  output ready);
endinterface

### hw/rtl/s2i_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_in_stage
// Input register: holds one character request until the parser core takes it.
// ----------------------------------------------------------------------------
module s2i_in_stage
  import s2i_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  req_valid,
  output logic  req_ready,
  input  item_t req_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  valid_r;
  item_t item_r;

  assign req_ready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item_r <= req_item;
    end
  end

endmodule

### hw/rtl/s2i_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_core
// Parser state and combinational character step: whitespace, sign, prefix,
// digit accumulate with clamp, and result formation on the last byte.
// ----------------------------------------------------------------------------
module s2i_core
  import s2i_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BASE_BITS-1:0] base_cfg,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_take,
  input  logic                 res_free,
  output logic                 res_load,
  output result_t              res
);

  state_t                state_r;
  state_t                state_nxt;
  state_t                step;
  logic                  do_take;
  logic [BASE_BITS-1:0]  d;
  logic [PROD_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] lim;
  logic [VALUE_BITS-1:0] mag;
  logic [CHAR_BITS-1:0]  c;

  assign c         = item.char_code;
  assign item_take = item_valid && (!item.last || res_free);
  assign res_load  = item_take && item.last;

  always_comb begin
    step    = state_r;
    do_take = 1'b0;
    d       = digit_value(c);

    unique case (state_r.phase)
      PH_SPACE, PH_START: begin
        if (state_r.phase == PH_SPACE && is_space(c)) begin
          step.phase = PH_SPACE;
        end else if (state_r.phase == PH_SPACE && c == CH_MINUS) begin
          step.negative = 1'b1;
          step.phase    = PH_START;
        end else if (state_r.phase == PH_SPACE && c == CH_PLUS) begin
          step.phase = PH_START;
        end else if ((base_cfg == BASE_AUTO || base_cfg == BASE_HEX) && c == CH_0) begin
          step.base   = base_cfg;
          step.acc    = '0;
          step.status = ST_SOME;
          step.dend   = next_pos(state_r.pos);
          step.phase  = PH_ZERO;
        end else begin
          step.base  = (base_cfg == BASE_AUTO) ? BASE_DEC : base_cfg;
          step.phase = PH_DIGITS;
          do_take    = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          step.base   = BASE_HEX;
          step.status = ST_NONE;
          step.dend   = '0;
          step.phase  = PH_DIGITS;
        end else begin
          if (state_r.base == BASE_AUTO) step.base = BASE_OCT;
          step.phase = PH_DIGITS;
          do_take    = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        step.phase = PH_DONE;
      end
    endcase

    lim  = mag_limit(step.negative);
    prod = PROD_BITS'(state_r.acc) * PROD_BITS'(step.base) + PROD_BITS'(d);

    if (do_take) begin
      if (step.base < BASE_MIN || step.base > BASE_MAX || d >= step.base) begin
        step.phase = PH_DONE;
      end else begin
        step.dend = next_pos(state_r.pos);
        if (state_r.status != ST_OVER) begin
          if (prod > PROD_BITS'(lim)) begin
            step.acc    = lim;
            step.status = ST_OVER;
          end else begin
            step.acc    = prod[VALUE_BITS-1:0];
            step.status = ST_SOME;
          end
        end
      end
    end
    step.pos = next_pos(state_r.pos);

    mag = (step.status == ST_NONE) ? '0 : step.acc;
    res.value       = step.negative ? $signed(-mag) : $signed(mag);
    res.end_offset  = (step.status == ST_NONE) ? '0 : step.dend;
    res.range_error = (step.status == ST_OVER);

    state_nxt = item.last ? STATE_RESET : step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (item_take) begin
      state_r <= state_nxt;
    end
  end

  a_over_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.status == ST_OVER) |-> (state_r.acc == mag_limit(state_r.negative)))
    else $error("overflowed accumulator not at its limit");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.status == ST_NONE) |-> (state_r.acc == '0))
    else $error("accumulator non-zero with no digit seen");

  a_dend_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.dend <= state_r.pos)
    else $error("digit end beyond character position");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r.phase == PH_SPACE && state_r.pos == '0))
    else $error("state not cleared after result");

endmodule

### hw/rtl/s2i_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_out_stage
// Result register: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module s2i_out_stage
  import s2i_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  output logic    res_free,
  output logic    req_valid,
  input  logic    req_ready,
  output result_t req_res
);

  logic    valid_r;
  result_t res_r;

  assign res_free  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_free) begin
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> valid_r)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !req_ready) |=> (valid_r && $stable(res_r)))
    else $error("stalled result lost or changed");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> res_free)
    else $error("result loaded while register busy");

endmodule

### hw/rtl/string_to_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtol: one byte per request, one signed 32-bit result per string.
// ----------------------------------------------------------------------------
// Send a string one byte per cycle on in_ch and mark its final byte with last;
// one result (value, end offset, range flag) follows on out_ch. Whitespace is
// skipped, a sign is read, and base 0 picks octal, decimal or hex from the
// prefix. The block takes a byte every cycle: each byte passes the input
// register and the combinational parse logic (a 32x6 multiply-add and limit
// compare); the result of a string's last byte is loaded into the result
// register and presented on out_ch from there.
// Only a stalled result on out_ch holds input back.
// Write cfg_wdata with cfg_we only while no string is in flight.
module string_to_integer_parser
  import s2i_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [BASE_BITS-1:0] cfg_wdata,
  s2i_in_if.sink               in_ch,
  s2i_out_if.source            out_ch
);

  logic [BASE_BITS-1:0] base_r;
  item_t                req_item;
  item_t                item;
  logic                 item_valid;
  logic                 item_take;
  logic                 res_free;
  logic                 res_load;
  result_t              res;
  result_t              out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  assign req_item.char_code = in_ch.char_code;
  assign req_item.last      = in_ch.last;

  s2i_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_ch.valid),
    .req_ready  (in_ch.ready),
    .req_item   (req_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  s2i_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_cfg   (base_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res)
  );

  s2i_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .req_valid (out_ch.valid),
    .req_ready (out_ch.ready),
    .req_res   (out_res)
  );

  assign out_ch.value       = out_res.value;
  assign out_ch.end_offset  = out_res.end_offset;
  assign out_ch.range_error = out_res.range_error;

endmodule

### tb/string_to_integer_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_test
// Self-checking bench for the streaming strtol parser. Strings go in one byte
// per request under random bursts and gaps. Each parsed result is compared
// with a cycle-free software parse of the same bytes. Directed strings cover
// whitespace, signs, prefixes, overflow, odd radices and long strings. A long
// result stall exercises input back-pressure, and random strings follow under
// a range of radix settings.
// ----------------------------------------------------------------------------
module string_to_integer_parser_test;
  import s2i_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [BASE_BITS-1:0] cfg_wdata;

  s2i_in_if  in_ch ();
  s2i_out_if out_ch ();

  string_to_integer_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // software parse state
  logic [BASE_BITS-1:0] number_base_cfg = BASE_RESET;
  phase_t               scan_phase;
  logic                 scan_negative;
  int unsigned          scan_base;
  longint unsigned      scan_mag;
  status_t              scan_status;
  logic [POS_BITS-1:0]  scan_pos;
  logic [POS_BITS-1:0]  scan_dend;

  result_t     awaited_numbers[$];
  result_t     head_result;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned chars_sent     = 0;
  int unsigned cycle_count    = 0;
  int          burst_left     = 0;
  bit          gaps_on        = 1'b1;
  int          holdoff_cycles = 0;
  int          pattern_age    = 0;
  logic [15:0] stall_pattern  = '1;

  function automatic logic [POS_BITS-1:0] step_pos(input logic [POS_BITS-1:0] p);
    return (p >= MAX_CHARS) ? POS_BITS'(MAX_CHARS) : p + 1'b1;
  endfunction

  function automatic void clear_scan();
    scan_phase    = PH_SPACE;
    scan_negative = 1'b0;
    scan_base     = 0;
    scan_mag      = 0;
    scan_status   = ST_NONE;
    scan_pos      = '0;
    scan_dend     = '0;
  endfunction

  function automatic void accept_digit(input logic [7:0] c, input logic [POS_BITS-1:0] p);
    int unsigned     d;
    longint unsigned lim;
    if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 10;
    else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 10;
    else d = 99;
    if (scan_base < BASE_MIN || scan_base > BASE_MAX || d >= scan_base) begin
      scan_phase = PH_DONE;
      return;
    end
    scan_dend = step_pos(p);
    if (scan_status == ST_OVER) return;
    lim = (64'd1 << (VALUE_BITS - 1)) - (scan_negative ? 64'd0 : 64'd1);
    if (scan_mag > (lim - d) / scan_base) begin
      scan_mag    = lim;
      scan_status = ST_OVER;
    end else begin
      scan_mag    = scan_mag * scan_base + d;
      scan_status = ST_SOME;
    end
  endfunction

  function automatic void open_number(input logic [7:0] c, input logic [POS_BITS-1:0] p);
    if ((number_base_cfg == BASE_AUTO || number_base_cfg == BASE_HEX) && c == CH_0) begin
      scan_base   = number_base_cfg;
      scan_mag    = 0;
      scan_status = ST_SOME;
      scan_dend   = step_pos(p);
      scan_phase  = PH_ZERO;
    end else begin
      scan_base  = (number_base_cfg == BASE_AUTO) ? BASE_DEC : number_base_cfg;
      scan_phase = PH_DIGITS;
      accept_digit(c, p);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input logic l);
    logic [POS_BITS-1:0]   p;
    logic [VALUE_BITS-1:0] mag;
    result_t               r;
    p = scan_pos;
    case (scan_phase)
      PH_SPACE: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        end else if (c == CH_MINUS) begin
          scan_negative = 1'b1;
          scan_phase    = PH_START;
        end else if (c == CH_PLUS) begin
          scan_phase = PH_START;
        end else begin
          open_number(c, p);
        end
      end
      PH_START: open_number(c, p);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          scan_base   = BASE_HEX;
          scan_status = ST_NONE;
          scan_dend   = '0;
          scan_phase  = PH_DIGITS;
        end else begin
          if (scan_base == BASE_AUTO) scan_base = BASE_OCT;
          scan_phase = PH_DIGITS;
          accept_digit(c, p);
        end
      end
      PH_DIGITS: accept_digit(c, p);
      default: ;
    endcase
    scan_pos = step_pos(p);
    if (l) begin
      mag           = (scan_status == ST_NONE) ? '0 : scan_mag[VALUE_BITS-1:0];
      r.value       = scan_negative ? -mag : mag;
      r.end_offset  = (scan_status == ST_NONE) ? '0 : scan_dend;
      r.range_error = (scan_status == ST_OVER);
      awaited_numbers.push_back(r);
      clear_scan();
    end
  endfunction

  task automatic send_request(input logic [7:0] c, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.last      = l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chars_sent++;
    parse_byte(c, l);
  endtask

  task automatic send_text(input string s, input bit close = 1'b1);
    for (int i = 0; i < s.len(); i++) send_request(s[i], close && i == s.len() - 1);
  endtask

  task automatic load_number_base(input logic [BASE_BITS-1:0] b);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited_numbers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = b;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we          = 1'b0;
    number_base_cfg = b;
  endtask

  task automatic send_random_string();
    logic [7:0]      text[$];
    int unsigned     radix, count, need, d;
    longint unsigned reach;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3))
        text.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      radix = (number_base_cfg >= BASE_MIN && number_base_cfg <= BASE_MAX) ?
              number_base_cfg : BASE_DEC;
      if (number_base_cfg == BASE_AUTO || number_base_cfg == BASE_HEX) begin
        case ($urandom_range(0, 3))
          0: begin
            text.push_back(CH_0);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            radix = BASE_HEX;
          end
          1: if (number_base_cfg == BASE_AUTO) begin
            text.push_back(CH_0);
            radix = BASE_OCT;
          end
          default: ;
        endcase
      end
      need  = 0;
      reach = 1;
      while (reach < (64'd1 << (VALUE_BITS - 1))) begin
        reach = reach * radix;
        need++;
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(need - 1, need + 3) :
                                            $urandom_range(0, 6);
      repeat (count) begin
        d = (radix > 2 && $urandom_range(0, 15) == 0) ? $urandom_range(0, 35) :
                                                        $urandom_range(0, radix - 1);
        text.push_back(d < 10 ? 8'(CH_0 + d) :
                       8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
      end
      if ($urandom_range(0, 5) == 0) text.push_back(8'h00);
      repeat ($urandom_range(0, 2)) text.push_back(8'($urandom));
    end
    if (text.size() == 0) text.push_back(8'($urandom));
    foreach (text[i]) send_request(text[i], i == text.size() - 1);
  endtask

  task automatic test_default_base();
    send_text(" 42");
    for (int c = CH_TAB; c <= CH_CR; c++) send_request(8'(c), 1'b0);
    send_text(" -123");
    send_text("+ 5");
    send_text("-+5");
    send_text("12", 1'b0);
    send_request(8'h00, 1'b0);
    send_text("34");
    send_request(8'h00, 1'b1);
    send_request(8'h80, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("7");
    send_text("9", 1'b0);
    send_request(8'hFE, 1'b1);
  endtask

  task automatic test_prefixes();
    load_number_base(BASE_HEX);
    send_text("0x1F");
    send_text("0X");
    send_text("0xg");
    send_text("0ff");
    send_text("-0x80000000");
    load_number_base(BASE_AUTO);
    send_text("017");
    send_text("019");
    send_text("0");
    send_text(" 0x7fffffff");
    send_text("-99");
  endtask

  task automatic test_overflow();
    load_number_base(BASE_DEC);
    send_text("2147483647");
    send_text("2147483648");
    send_text("-2147483648");
    send_text("-2147483649");
    send_text("99999999999999999999xyz");
  endtask

  task automatic test_radix_extremes();
    load_number_base(BASE_MIN);
    send_text("1012");
    load_number_base(BASE_MAX);
    send_text("zZ");
    send_text("-ZZZZZZZZZZ");
    load_number_base(6'd1);
    send_text("0");
    load_number_base(6'd37);
    send_text("1");
    load_number_base(6'd63);
    send_text("1a");
  endtask

  task automatic test_long_strings();
    load_number_base(BASE_DEC);
    repeat (250) send_request(CH_0, 1'b0);
    send_text("5");
    repeat (150) send_request(CH_SPACE, 1'b0);
    send_text("-9");
  endtask

  task automatic test_back_pressure();
    load_number_base(BASE_DEC);
    holdoff_cycles = 300;
    repeat (40) send_random_string();
  endtask

  task automatic test_random_strings();
    logic [BASE_BITS-1:0] radix_plan[$];
    int unsigned          results0, phase_idx, phase_chars;
    radix_plan = '{BASE_AUTO, BASE_MAX, BASE_MIN, BASE_DEC, BASE_HEX, BASE_OCT,
                   6'd1, 6'd37, 6'd63};
    results0  = results_seen;
    phase_idx = 0;
    while (chars_sent < 1650 || results_seen - results0 < 48) begin
      load_number_base(phase_idx < radix_plan.size() ? radix_plan[phase_idx] :
                       BASE_BITS'($urandom_range(0, 63)));
      gaps_on     = ($urandom_range(0, 3) != 0);
      phase_chars = chars_sent;
      while (chars_sent - phase_chars < 90) send_random_string();
      phase_idx++;
    end
  endtask

  // result side: stall pattern, with an occasional long hold
  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles--;
      out_ch.ready = 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom);
        endcase
        if (stall_pattern == '0) stall_pattern = 16'h0001;
      end
      pattern_age--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      out_ch.ready  = stall_pattern[15];
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (awaited_numbers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result at %0t: value %0d end %0d range %0b", $time,
                   out_ch.value, out_ch.end_offset, out_ch.range_error);
        mismatch_count++;
      end else begin
        head_result = awaited_numbers.pop_front();
        if (out_ch.value !== head_result.value ||
            out_ch.end_offset !== head_result.end_offset ||
            out_ch.range_error !== head_result.range_error) begin
          if (mismatch_count < 10)
            $display("mismatch at %0t: expected %0d/%0d/%0b, got %0d/%0d/%0b", $time,
                     head_result.value, head_result.end_offset, head_result.range_error,
                     out_ch.value, out_ch.end_offset, out_ch.range_error);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int drain;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    clear_scan();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_default_base();
    test_prefixes();
    test_overflow();
    test_radix_extremes();
    test_long_strings();
    test_back_pressure();
    test_random_strings();

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain = 0;
    while (awaited_numbers.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (awaited_numbers.size() != 0) begin
      $display("results missing: %0d", awaited_numbers.size());
      mismatch_count += awaited_numbers.size();
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/s2i_pkg.sv
hw/rtl/s2i_in_if.sv
hw/rtl/s2i_out_if.sv
hw/rtl/s2i_in_stage.sv
hw/rtl/s2i_core.sv
hw/rtl/s2i_out_stage.sv
hw/rtl/string_to_integer_parser.sv
tb/string_to_integer_parser_test.sv
